[hw/rtl/nmea_rmc_time_date_extractor_macros.svh]
// ----------------------------------------------------------------------------
// NMEA RMC extractor assertion macros
// Property helpers for the extractor RTL, which carries the assertions.
// ----------------------------------------------------------------------------
`ifndef NMEA_RMC_TIME_DATE_EXTRACTOR_MACROS_SVH
`define NMEA_RMC_TIME_DATE_EXTRACTOR_MACROS_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define NRTE_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled during reset.
`define NRTE_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/nrte_pkg.sv]
// ----------------------------------------------------------------------------
// NMEA RMC extractor package
// Types, character constants and small helper functions for the extractor.
// ----------------------------------------------------------------------------
package nrte_pkg;

   localparam int unsigned ValW  = 7;
   localparam int unsigned CapN  = 12;
   localparam int unsigned CapIw = 4;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_G      = 8'h47;
   localparam logic [7:0] CHAR_N      = 8'h4E;
   localparam logic [7:0] CHAR_P      = 8'h50;
   localparam logic [7:0] CHAR_R      = 8'h52;
   localparam logic [7:0] CHAR_M      = 8'h4D;
   localparam logic [7:0] CHAR_C      = 8'h43;

   localparam logic [2:0] HDR_LAST   = 3'd6;
   localparam logic [2:0] SKIP_LAST  = 3'd7;
   localparam logic [2:0] FIELD_LAST = 3'd5;
   localparam logic [CapIw-1:0] DATE_BASE = 4'd6;

   localparam logic [ValW-1:0] HOUR_MAX   = 7'd23;
   localparam logic [ValW-1:0] MINUTE_MAX = 7'd59;
   localparam logic [ValW-1:0] SECOND_MAX = 7'd59;
   localparam logic [ValW-1:0] DAY_MAX    = 7'd31;
   localparam logic [ValW-1:0] MONTH_MAX  = 7'd12;

   localparam logic [ValW-1:0] YEAR_MIN_RST = 7'd18;
   localparam logic [ValW-1:0] YEAR_MAX_RST = 7'd30;

   typedef enum logic [1:0] {
      CSR_YEAR_MIN = 2'd0,
      CSR_YEAR_MAX = 2'd1
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_HUNT = 4'b0001,
      PH_TIME = 4'b0010,
      PH_SKIP = 4'b0100,
      PH_DATE = 4'b1000
   } phase_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   // Both headers share every position except the third, N or P.
   function automatic logic hdr_match(input logic [2:0] pos, input logic [7:0] c);
      logic hit;
      hit = 1'b0;
      unique case (pos)
         3'd0:    hit = (c == CHAR_DOLLAR);
         3'd1:    hit = (c == CHAR_G);
         3'd2:    hit = (c == CHAR_N) || (c == CHAR_P);
         3'd3:    hit = (c == CHAR_R);
         3'd4:    hit = (c == CHAR_M);
         3'd5:    hit = (c == CHAR_C);
         3'd6:    hit = (c == CHAR_COMMA);
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   // Tens digit times ten plus units digit, as shifts and adds.
   function automatic logic [ValW-1:0] pair_value(input logic [7:0] hi, input logic [7:0] lo);
      return {hi[3:0], 3'b000} + {2'b00, hi[3:0], 1'b0} + {3'b000, lo[3:0]};
   endfunction

endpackage

[hw/rtl/nmea_rmc_time_date_extractor.sv]
// ----------------------------------------------------------------------------
// NMEA RMC time and date extractor
// Scans a GPS byte stream for RMC sentences and reports UTC time and date.
// ----------------------------------------------------------------------------
// Usage:
// Bytes enter on the req_ channel, one request per byte, and each byte is
// stored in an input register before it is parsed. Once a "$GNRMC," or
// "$GPRMC," header is seen, the six time characters and, after eight more
// commas, the six date characters are captured. The last date character
// produces one response on the rsp_ channel carrying the converted fields
// and a bad_fix flag for non-digit or out-of-range characters.
// The last date byte is first held in the input register, and its converted
// fields are then loaded into the response register once that register is free.
// Throughput is one byte per cycle unless a completing byte waits, set by the
// single parse stage between the input register and the response register.
// When the receiver stalls, bytes that produce no response keep flowing; only
// a byte that would complete a response waits in the input register until the
// response register is free, which then holds req_ready low.
// Users must write the year bounds via csr_ while the block is idle; it does not enforce this.
// Reset returns the parser to the header hunt, empties both registers and
// restores the year bounds to 18 and 30.
// ----------------------------------------------------------------------------
`include "nmea_rmc_time_date_extractor_macros.svh"

module nmea_rmc_time_date_extractor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_hour,
   output logic [6:0] rsp_minute,
   output logic [6:0] rsp_second,
   output logic [6:0] rsp_day,
   output logic [6:0] rsp_month,
   output logic [6:0] rsp_year,
   output logic       rsp_bad_fix,
   input  logic       csr_write_en,
   input  logic [1:0] csr_index,
   input  logic [6:0] csr_wdata
);

   localparam int unsigned VW = nrte_pkg::ValW;
   localparam int unsigned IW = nrte_pkg::CapIw;

   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   nrte_pkg::phase_type  phase_ff, phase_in;
   logic [2:0]           match_ff, match_in;
   logic [2:0]           pos_ff, pos_in;
   logic [7:0]           chars_ff [nrte_pkg::CapN];
   logic [VW-1:0]        year_min_ff, year_max_ff;

   logic                 rsp_valid_ff;
   logic [VW-1:0]        hour_ff, minute_ff, second_ff, day_ff, month_ff, year_ff;
   logic                 bad_fix_ff;

   logic                 is_comma;
   logic                 cap_we;
   logic [IW-1:0]        cap_idx;
   logic                 emit;
   logic                 advance;
   logic                 emit_fire;
   logic                 hunting;
   logic                 capturing;
   logic                 blocked;

   logic                 all_digits;
   logic [VW-1:0]        hour_in, minute_in, second_in, day_in, month_in, year_in;
   logic                 bad_fix_in;

   assign is_comma = (in_byte_ff == nrte_pkg::CHAR_COMMA);

   // Parse step for the byte held in the input register.
   always_comb begin
      phase_in = phase_ff;
      match_in = match_ff;
      pos_in   = pos_ff;
      cap_we   = 1'b0;
      cap_idx  = {1'b0, pos_ff};
      emit     = 1'b0;
      unique case (phase_ff)
         nrte_pkg::PH_TIME: begin
            if (is_comma) begin
               phase_in = nrte_pkg::PH_HUNT;
               match_in = 3'd0;
            end else begin
               cap_we = 1'b1;
               if (pos_ff == nrte_pkg::FIELD_LAST) begin
                  phase_in = nrte_pkg::PH_SKIP;
                  pos_in   = 3'd0;
                  match_in = 3'd0;
               end else begin
                  pos_in = pos_ff + 3'd1;
               end
            end
         end
         nrte_pkg::PH_SKIP: begin
            if (is_comma) begin
               if (match_ff == nrte_pkg::SKIP_LAST) begin
                  phase_in = nrte_pkg::PH_DATE;
                  pos_in   = 3'd0;
                  match_in = 3'd0;
               end else begin
                  match_in = match_ff + 3'd1;
               end
            end
         end
         nrte_pkg::PH_DATE: begin
            cap_idx = nrte_pkg::DATE_BASE + {1'b0, pos_ff};
            if (is_comma) begin
               phase_in = nrte_pkg::PH_HUNT;
               match_in = 3'd0;
            end else begin
               cap_we = 1'b1;
               if (pos_ff == nrte_pkg::FIELD_LAST) begin
                  phase_in = nrte_pkg::PH_HUNT;
                  match_in = 3'd0;
                  emit     = 1'b1;
               end else begin
                  pos_in = pos_ff + 3'd1;
               end
            end
         end
         default: begin
            phase_in = nrte_pkg::PH_HUNT;
            if (nrte_pkg::hdr_match(match_ff, in_byte_ff)) begin
               if (match_ff == nrte_pkg::HDR_LAST) begin
                  phase_in = nrte_pkg::PH_TIME;
                  match_in = 3'd0;
                  pos_in   = 3'd0;
               end else begin
                  match_in = match_ff + 3'd1;
               end
            end else begin
               match_in = 3'd0;
            end
         end
      endcase
   end

   // The last year character is still in the input register, not the array.
   always_comb begin
      all_digits = nrte_pkg::is_digit(in_byte_ff);
      for (int i = 0; i < nrte_pkg::CapN - 1; i++) begin
         all_digits = all_digits & nrte_pkg::is_digit(chars_ff[i]);
      end
      hour_in   = '0;
      minute_in = '0;
      second_in = '0;
      day_in    = '0;
      month_in  = '0;
      year_in   = '0;
      if (all_digits) begin
         hour_in   = nrte_pkg::pair_value(chars_ff[0], chars_ff[1]);
         minute_in = nrte_pkg::pair_value(chars_ff[2], chars_ff[3]);
         second_in = nrte_pkg::pair_value(chars_ff[4], chars_ff[5]);
         day_in    = nrte_pkg::pair_value(chars_ff[6], chars_ff[7]);
         month_in  = nrte_pkg::pair_value(chars_ff[8], chars_ff[9]);
         year_in   = nrte_pkg::pair_value(chars_ff[10], in_byte_ff);
      end
      bad_fix_in = !all_digits
                   || (hour_in > nrte_pkg::HOUR_MAX)
                   || (minute_in > nrte_pkg::MINUTE_MAX)
                   || (second_in > nrte_pkg::SECOND_MAX)
                   || (day_in > nrte_pkg::DAY_MAX)
                   || (month_in > nrte_pkg::MONTH_MAX)
                   || (year_in < year_min_ff)
                   || (year_in > year_max_ff);
   end

   // Only a byte that completes a response has to wait for the output register.
   assign advance   = in_valid_ff && (!emit || !rsp_valid_ff || rsp_ready);
   assign emit_fire = advance && emit;
   assign req_ready = !in_valid_ff || advance;

   assign hunting   = (phase_ff == nrte_pkg::PH_HUNT);
   assign capturing = (phase_ff == nrte_pkg::PH_TIME) || (phase_ff == nrte_pkg::PH_DATE);
   assign blocked   = in_valid_ff && emit && rsp_valid_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= nrte_pkg::PH_HUNT;
         match_ff <= 3'd0;
         pos_ff   <= 3'd0;
      end else if (advance) begin
         phase_ff <= phase_in;
         match_ff <= match_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && cap_we) begin
         chars_ff[cap_idx] <= in_byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         year_min_ff <= nrte_pkg::YEAR_MIN_RST;
         year_max_ff <= nrte_pkg::YEAR_MAX_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            nrte_pkg::CSR_YEAR_MIN: year_min_ff <= csr_wdata;
            nrte_pkg::CSR_YEAR_MAX: year_max_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         hour_ff    <= hour_in;
         minute_ff  <= minute_in;
         second_ff  <= second_in;
         day_ff     <= day_in;
         month_ff   <= month_in;
         year_ff    <= year_in;
         bad_fix_ff <= bad_fix_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_hour    = hour_ff;
   assign rsp_minute  = minute_ff;
   assign rsp_second  = second_ff;
   assign rsp_day     = day_ff;
   assign rsp_month   = month_ff;
   assign rsp_year    = year_ff;
   assign rsp_bad_fix = bad_fix_ff;

   `NRTE_ASSERT_IMP(a_pos_in_field, capturing, pos_ff <= nrte_pkg::FIELD_LAST, "bad position")
   `NRTE_ASSERT_IMP(a_hunt_match, hunting, match_ff <= nrte_pkg::HDR_LAST, "bad header position")
   `NRTE_ASSERT_NXT(a_emit_loads, emit_fire, rsp_valid_ff, "no response raised")
   `NRTE_ASSERT_IMP(a_stall_cause, !req_ready, blocked, "stall without blocked response")

endmodule
